>>> rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  // Radicand: trace+one or one+d_k-d_i-d_j, inputs 16-bit signed.
  localparam int RW = 19;
  // Square-root operand r << (FRAC_BITS+2), always positive when used.
  localparam int SQ_OPW = RW + FRAC_BITS + 2;
  localparam int SQ_STEPS = (SQ_OPW + 1) / 2;
  localparam int SW = SQ_STEPS;
  // Off-diagonal numerator magnitude fits in 17 bits.
  localparam int NW = 18;
  localparam int DIVW = NW + FRAC_BITS;
  localparam int QW = DIVW;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0] branch_taken;
    logic degenerate;
  } out_word_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [RW-1:0] rad;
    logic signed [17:0] nw;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic [1:0] br;
    logic deg;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic signed [QW:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

endpackage

>>> rtl/rotation_matrix_to_quaternion_top.sv
// Converts a Q1.14 rotation matrix to its unit quaternion by Shepperd's method.
// One word is accepted per cycle while in_stall is low; each word passes through
// the classifying front end, the four-entry queue, the bit-per-stage square root,
// the bit-per-stage dividers and the output register of the back end.
module rotation_matrix_to_quaternion_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rmq_pkg::in_word_t   in_data,
  output logic                in_stall,
  output logic                out_valid,
  output rmq_pkg::out_word_t  out_data,
  input  logic                out_stall
);
  import rmq_pkg::*;

  logic f_valid, f_stall, q_valid, q_take;
  job_t f_job, q_job;

  rmq_front u_front (
    .clk, .rst_n, .in_valid, .in_data, .in_stall,
    .job_valid(f_valid), .job(f_job), .job_stall(f_stall)
  );

  rmq_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_data(f_job), .wr_stall(f_stall),
    .rd_valid(q_valid), .rd_data(q_job), .rd_take(q_take)
  );

  rmq_back u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(q_job), .job_take(q_take),
    .out_valid, .out_data, .out_stall
  );
endmodule

>>> rtl/rmq_front.sv
module rmq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rmq_pkg::in_word_t  in_data,
  output logic               in_stall,
  output logic               job_valid,
  output rmq_pkg::job_t      job,
  input  logic               job_stall
);
  import rmq_pkg::*;

  logic signed [17:0] d0, d1, d2, tr;
  logic signed [RW-1:0] r;
  job_t j;
  job_t job_r;
  logic job_valid_r;

  always_comb begin
    d0 = 18'(in_data.m00);
    d1 = 18'(in_data.m11);
    d2 = 18'(in_data.m22);
    tr = d0 + d1 + d2;
    j = '0;
    if (tr > 0) begin
      j.br = BR_TRACE;
      r = RW'(tr) + RW'(1 << FRAC_BITS);
      j.nx = 18'(in_data.m21) - 18'(in_data.m12);
      j.ny = 18'(in_data.m02) - 18'(in_data.m20);
      j.nz = 18'(in_data.m10) - 18'(in_data.m01);
    end else if (d0 > d1 && d0 > d2) begin
      j.br = BR_X;
      r = RW'(1 << FRAC_BITS) + RW'(d0) - RW'(d1) - RW'(d2);
      j.nw = 18'(in_data.m21) - 18'(in_data.m12);
      j.ny = 18'(in_data.m01) + 18'(in_data.m10);
      j.nz = 18'(in_data.m02) + 18'(in_data.m20);
    end else if (d1 > d2) begin
      j.br = BR_Y;
      r = RW'(1 << FRAC_BITS) + RW'(d1) - RW'(d0) - RW'(d2);
      j.nw = 18'(in_data.m02) - 18'(in_data.m20);
      j.nx = 18'(in_data.m01) + 18'(in_data.m10);
      j.nz = 18'(in_data.m12) + 18'(in_data.m21);
    end else begin
      j.br = BR_Z;
      r = RW'(1 << FRAC_BITS) + RW'(d2) - RW'(d0) - RW'(d1);
      j.nw = 18'(in_data.m10) - 18'(in_data.m01);
      j.nx = 18'(in_data.m02) + 18'(in_data.m20);
      j.ny = 18'(in_data.m12) + 18'(in_data.m21);
    end
    j.deg = (r <= 0);
    j.rad = j.deg ? RW'(1) : r;
  end

  assign in_stall = job_valid_r && job_stall;
  assign job_valid = job_valid_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (!in_stall) begin
      job_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      job_r <= j;
    end
  end
endmodule

>>> rtl/rmq_fifo.sv
module rmq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  input  rmq_pkg::job_t  wr_data,
  output logic           wr_stall,
  output logic           rd_valid,
  output rmq_pkg::job_t  rd_data,
  input  logic           rd_take
);
  import rmq_pkg::*;

  job_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0] cnt_r;
  logic wr, rd;

  assign wr_stall = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      if (wr && !rd) cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

>>> rtl/rmq_back.sv
module rmq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  rmq_pkg::job_t      job,
  output logic               job_take,
  output logic               out_valid,
  output rmq_pkg::out_word_t out_data,
  input  logic               out_stall
);
  import rmq_pkg::*;

  localparam int NS = SQ_STEPS;
  localparam int ND = DIVW;

  // Whole pipeline advances together; it moves when the output is free.
  logic adv;

  // Square-root stages: remainder, root, operand shifted left two bits per stage.
  logic [NS:0] sv_r;
  logic [SW+1:0] srem_r [NS+1];
  logic [SW-1:0] sroot_r [NS+1];
  logic [2*NS-1:0] sop_r [NS+1];
  job_t sj_r [NS+1];

  // Divider stages: three lanes of restoring division.
  localparam int DL = ND + 1;
  logic [DL-1:0] dv_r;
  logic [SW:0] drem_r [DL][3];
  logic [ND-1:0] dq_r [DL][3];
  logic [ND-1:0] dn_r [DL][3];
  logic dneg_r [DL][3];
  logic [SW-1:0] ds_r [DL];
  job_t dj_r [DL];

  out_word_t out_r;
  logic out_valid_r;

  assign adv = !out_valid_r || !out_stall;
  assign job_take = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      dv_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sv_r <= {sv_r[NS-1:0], job_valid};
      dv_r <= {dv_r[DL-2:0], sv_r[NS]};
      out_valid_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem_r[0] <= '0;
      sroot_r[0] <= '0;
      sop_r[0] <= (2*NS)'({job.rad, (FRAC_BITS+2)'(0)});
      sj_r[0] <= job;
      for (int i = 0; i < NS; i++) begin
        logic [SW+1:0] rem, trial;
        rem = {srem_r[i][SW-1:0], sop_r[i][2*NS-1 -: 2]};
        trial = {sroot_r[i], 2'b01};
        if (rem >= trial) begin
          srem_r[i+1] <= rem - trial;
          sroot_r[i+1] <= {sroot_r[i][SW-2:0], 1'b1};
        end else begin
          srem_r[i+1] <= rem;
          sroot_r[i+1] <= {sroot_r[i][SW-2:0], 1'b0};
        end
        sop_r[i+1] <= {sop_r[i][2*NS-3:0], 2'b00};
        sj_r[i+1] <= sj_r[i];
      end
    end
  end

  // Divider input: magnitude scaled by 2^FRAC_BITS plus half the divisor.
  logic [ND-1:0] dnum [3];
  logic dsgn [3];
  logic signed [17:0] nsel [3];
  logic [SW-1:0] s0;
  always_comb begin
    s0 = sroot_r[NS];
    case (sj_r[NS].br)
      BR_TRACE: begin nsel[0] = sj_r[NS].nx; nsel[1] = sj_r[NS].ny; nsel[2] = sj_r[NS].nz; end
      BR_X: begin nsel[0] = sj_r[NS].nw; nsel[1] = sj_r[NS].ny; nsel[2] = sj_r[NS].nz; end
      BR_Y: begin nsel[0] = sj_r[NS].nw; nsel[1] = sj_r[NS].nx; nsel[2] = sj_r[NS].nz; end
      default: begin nsel[0] = sj_r[NS].nw; nsel[1] = sj_r[NS].nx; nsel[2] = sj_r[NS].ny; end
    endcase
    for (int k = 0; k < 3; k++) begin
      logic [NW-1:0] mag;
      dsgn[k] = nsel[k] < 0;
      mag = dsgn[k] ? NW'(-nsel[k]) : NW'(nsel[k]);
      dnum[k] = ND'({mag, FRAC_BITS'(0)}) + ND'(s0 >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0] <= s0;
      dj_r[0] <= sj_r[NS];
      for (int k = 0; k < 3; k++) begin
        drem_r[0][k] <= '0;
        dq_r[0][k] <= '0;
        dn_r[0][k] <= dnum[k];
        dneg_r[0][k] <= dsgn[k];
      end
      for (int i = 0; i < DL-1; i++) begin
        ds_r[i+1] <= ds_r[i];
        dj_r[i+1] <= dj_r[i];
        for (int k = 0; k < 3; k++) begin
          logic [SW+1:0] rem;
          rem = {drem_r[i][k], dn_r[i][k][ND-1]};
          if (rem >= (SW+2)'(ds_r[i])) begin
            drem_r[i+1][k] <= (SW+1)'(rem - (SW+2)'(ds_r[i]));
            dq_r[i+1][k] <= {dq_r[i][k][ND-2:0], 1'b1};
          end else begin
            drem_r[i+1][k] <= rem[SW:0];
            dq_r[i+1][k] <= {dq_r[i][k][ND-2:0], 1'b0};
          end
          dn_r[i+1][k] <= {dn_r[i][k][ND-2:0], 1'b0};
          dneg_r[i+1][k] <= dneg_r[i][k];
        end
      end
    end
  end

  logic signed [15:0] v [3];
  logic signed [15:0] big;
  out_word_t o;
  job_t jl;
  always_comb begin
    jl = dj_r[DL-1];
    for (int k = 0; k < 3; k++) begin
      logic signed [QW:0] q;
      q = signed'({1'b0, dq_r[DL-1][k]});
      v[k] = sat16(dneg_r[DL-1][k] ? -q : q);
    end
    big = sat16((QW+1)'((ds_r[DL-1] + SW'(2)) >> 2));
    o = '0;
    o.branch_taken = jl.br;
    o.degenerate = jl.deg;
    if (!jl.deg) begin
      case (jl.br)
        BR_TRACE: begin o.quat_w = big; o.quat_x = v[0]; o.quat_y = v[1]; o.quat_z = v[2]; end
        BR_X: begin o.quat_x = big; o.quat_w = v[0]; o.quat_y = v[1]; o.quat_z = v[2]; end
        BR_Y: begin o.quat_y = big; o.quat_w = v[0]; o.quat_x = v[1]; o.quat_z = v[2]; end
        default: begin o.quat_z = big; o.quat_w = v[0]; o.quat_x = v[1]; o.quat_y = v[2]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= o;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
